// File: hw/rtl/pesq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesq_pkg
// shared types and constants of the periodic event sample qualifier
// ----------------------------------------------------------------------------
package pesq_pkg;

	localparam int FIELD_BITS  = 32;
	localparam int PERIOD_BITS = 20;

	localparam int unsigned PERIOD_RESET = 86400;
	localparam int unsigned DELTA_RESET  = 3600;

	localparam logic CFG_EVENT_PERIOD = 1'b0;
	localparam logic CFG_MAX_DELTA    = 1'b1;

	localparam logic FUNC_CHECK = 1'b0;
	localparam logic FUNC_PUSH  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LATEST,
		ST_LATEST,
		ST_RD_ENT,
		ST_ENT,
		ST_ENT_DIV,
		ST_AVG,
		ST_AVG_DIV,
		ST_CHK,
		ST_CHK_DIV,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/periodic_event_sample_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_sample_qualifier
// ring of recent event times in ram, checks a new time against the set
// ----------------------------------------------------------------------------
// push word: a nonzero time is written to the ring on acceptance, then ST_DONE
// check word: reads the latest sample, walks the older ones, then the average and
// the fit check follow; offsets go through the one-bit-per-cycle divider
// and in_stall is low only in ST_IDLE; one word in flight at a time
// reset returns head, count and config to defaults; ring contents are not cleared
module periodic_event_sample_qualifier
	import pesq_pkg::*;
#(
	parameter int RING_DEPTH = 8,
	parameter int TIME_BITS  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [FIELD_BITS-1:0]  sample_time,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   good,
	output logic                   estimate_valid,
	output logic [FIELD_BITS-1:0]  estimate,
	output logic                   fault,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [PERIOD_BITS-1:0] cfg_wdata
);

	localparam int PTR_BITS = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(RING_DEPTH + 1);
	localparam int SUM_BITS = PERIOD_BITS + 3 + CNT_BITS;
	localparam int DW       = (TIME_BITS > SUM_BITS) ? TIME_BITS : SUM_BITS;

	state_t state_q, state_d;

	logic [PERIOD_BITS-1:0] period_q, delta_q, per;
	logic [PTR_BITS-1:0]    head_q, rd_ptr_q;
	logic [CNT_BITS-1:0]    count_q, idx_q, idx_nxt;
	logic [TIME_BITS-1:0]   t_in, t_q, latest_q, est_q, rdata;
	logic                   ok_q, fault_q, ev_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [SUM_BITS-1:0]    sum_mag;
	logic                   in_acc, push_wr, out_load;
	logic                   div_start, div_done;
	logic [DW-1:0]          div_dvd, div_quo, avg_dw;
	logic [PERIOD_BITS-1:0] div_dvs, div_rem;
	logic [PERIOD_BITS-1:0] w, back;
	logic [PERIOD_BITS:0]   delta2;
	logic                   ent_late, chk_late, more;

	assign t_in    = TIME_BITS'(sample_time);
	assign in_acc  = in_valid && !in_stall;
	assign push_wr = in_acc && (func == FUNC_PUSH) && (t_in != '0);
	assign per     = (period_q == '0) ? PERIOD_BITS'(1) : period_q;
	assign delta2  = {delta_q, 1'b0};
	assign idx_nxt = idx_q + 1'b1;
	assign more    = idx_nxt < count_q;
	assign ent_late = latest_q < rdata;
	assign chk_late = t_q < est_q;

	assign w    = (div_rem == '0) ? '0 : per - div_rem;
	assign back = per - w;

	assign sum_mag = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
	assign avg_dw  = sum_q[SUM_BITS-1] ? -div_quo : div_quo;

	pesq_ram #(.WIDTH(TIME_BITS), .DEPTH(RING_DEPTH)) u_ram (
		.clk   (clk),
		.we    (push_wr),
		.waddr (head_q),
		.wdata (t_in),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	pesq_div #(.DW(DW), .VW(PERIOD_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (func == FUNC_PUSH || count_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_RD_LATEST;
					end
				end
			end
			ST_RD_LATEST: state_d = ST_LATEST;
			ST_LATEST:    state_d = (count_q > CNT_BITS'(1)) ? ST_RD_ENT : ST_AVG;
			ST_RD_ENT:    state_d = ST_ENT;
			ST_ENT: begin
				if (ent_late) begin
					state_d = more ? ST_RD_ENT : ST_AVG;
				end else begin
					state_d = ST_ENT_DIV;
				end
			end
			ST_ENT_DIV: begin
				if (div_done) begin
					state_d = more ? ST_RD_ENT : ST_AVG;
				end
			end
			ST_AVG:     state_d = ST_AVG_DIV;
			ST_AVG_DIV: state_d = div_done ? ST_CHK : ST_AVG_DIV;
			ST_CHK:     state_d = chk_late ? ST_DONE : ST_CHK_DIV;
			ST_CHK_DIV: state_d = div_done ? ST_DONE : ST_CHK_DIV;
			ST_DONE:    state_d = out_load ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = per;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_ENT: begin
				div_start = !ent_late;
				div_dvd   = DW'(latest_q - rdata);
			end
			ST_AVG: begin
				div_start = 1'b1;
				div_dvd   = DW'(sum_mag);
				div_dvs   = PERIOD_BITS'(count_q);
			end
			ST_CHK: begin
				div_start = !chk_late;
				div_dvd   = DW'(t_q - est_q);
			end
			ST_DONE: out_load = !out_valid || !out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			period_q  <= PERIOD_BITS'(PERIOD_RESET);
			delta_q   <= PERIOD_BITS'(DELTA_RESET);
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_EVENT_PERIOD: period_q <= cfg_wdata;
					CFG_MAX_DELTA:    delta_q  <= cfg_wdata;
					default:          period_q <= period_q;
				endcase
			end
			if (push_wr) begin
				head_q <= (head_q == PTR_BITS'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
				if (count_q != CNT_BITS'(RING_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q      <= t_in;
				ok_q     <= (func == FUNC_CHECK);
				fault_q  <= 1'b0;
				ev_q     <= 1'b0;
				est_q    <= '0;
				sum_q    <= '0;
				idx_q    <= CNT_BITS'(1);
				rd_ptr_q <= (head_q == '0) ? PTR_BITS'(RING_DEPTH - 1) : head_q - 1'b1;
			end
			ST_LATEST: begin
				latest_q <= rdata;
				ev_q     <= 1'b1;
				rd_ptr_q <= (rd_ptr_q == '0) ? PTR_BITS'(RING_DEPTH - 1) : rd_ptr_q - 1'b1;
			end
			ST_ENT: begin
				if (ent_late) begin
					fault_q  <= 1'b1;
					idx_q    <= idx_nxt;
					rd_ptr_q <= (rd_ptr_q == '0) ? PTR_BITS'(RING_DEPTH - 1) : rd_ptr_q - 1'b1;
				end
			end
			ST_ENT_DIV: begin
				if (div_done) begin
					if ({1'b0, w} < delta2) begin
						sum_q <= sum_q + SUM_BITS'(w);
					end else if ({1'b0, back} < delta2) begin
						sum_q <= sum_q - SUM_BITS'(back);
					end else begin
						fault_q <= 1'b1;
					end
					idx_q    <= idx_nxt;
					rd_ptr_q <= (rd_ptr_q == '0) ? PTR_BITS'(RING_DEPTH - 1) : rd_ptr_q - 1'b1;
				end
			end
			ST_AVG_DIV: begin
				if (div_done) begin
					est_q <= latest_q + avg_dw[TIME_BITS-1:0];
				end
			end
			ST_CHK: begin
				if (chk_late) begin
					fault_q <= 1'b1;
					ok_q    <= 1'b0;
				end
			end
			ST_CHK_DIV: begin
				if (div_done) begin
					ok_q <= (w < delta_q) || (back < delta_q);
				end
			end
			ST_DONE: begin
				if (out_load) begin
					good           <= ok_q && !fault_q;
					estimate_valid <= ev_q;
					estimate       <= FIELD_BITS'(64'(est_q));
					fault          <= fault_q;
				end
			end
			default: t_q <= t_q;
		endcase
	end

endmodule

// File: hw/rtl/pesq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesq_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pesq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/pesq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesq_div
// iterative unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pesq_div #(
	parameter int DW = 32,
	parameter int VW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/pesq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesq_checker
// port level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module pesq_checker
	import pesq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  good,
	input logic                  estimate_valid,
	input logic [FIELD_BITS-1:0] estimate,
	input logic                  fault
);

	// stalled word holds its valid, estimate and good
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(estimate) && $stable(good))
		else $error("stalled result word changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> !good)
		else $error("good raised with fault");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !estimate_valid |-> estimate == '0)
		else $error("estimate set without estimate_valid");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !estimate_valid |-> !fault)
		else $error("fault without an estimate");

endmodule

bind periodic_event_sample_qualifier pesq_checker u_pesq_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the periodic event sample qualifier: a directed
// set of pushes and checks, then random daily-like sequences with noise
// under several period and delta settings, checked against an in-bench
// predictor of the ring, the average offset and the fit decision
// ----------------------------------------------------------------------------
module testbench;
	import pesq_pkg::*;

	localparam int DEPTH      = 8;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic        good;
		logic        estimate_valid;
		logic [31:0] estimate;
		logic        fault;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, func, out_stall, cfg_we, cfg_index;
	logic [FIELD_BITS-1:0] sample_time;
	logic [PERIOD_BITS-1:0] cfg_wdata;
	logic in_stall, out_valid, good, estimate_valid, fault;
	logic [FIELD_BITS-1:0] estimate;

	periodic_event_sample_qualifier u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .sample_time(sample_time),
		.out_valid(out_valid), .out_stall(out_stall),
		.good(good), .estimate_valid(estimate_valid),
		.estimate(estimate), .fault(fault),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [31:0] times_ring [DEPTH];
	int unsigned ring_wr, ring_fill;
	logic [63:0] period_q, delta_q;

	verdict_t verdict_q[$];
	int errors, n_words, n_checks, n_good, n_faults, idle_cycles;
	bit burst;
	int hold_long;

	function automatic bit project_near(input logic [63:0] t, input logic [63:0] anchor,
		input logic [63:0] dlt, output longint off, inout bit flt);
		logic [63:0] per, r, w, back;
		per = (period_q != 0) ? period_q : 64'd1;
		off = 0;
		if (anchor < t) begin
			flt = 1'b1;
			return 1'b0;
		end
		r = (anchor - t) % per;
		w = (r != 0) ? per - r : 64'd0;
		if (w < dlt) begin
			off = longint'(w);
			return 1'b1;
		end
		back = per - w;
		if (back < dlt) begin
			off = -longint'(back);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic verdict_t qualify(input logic f, input logic [31:0] t);
		verdict_t v;
		logic [63:0] latest;
		longint sum, off, avg;
		bit flt, ok;
		logic [31:0] est;
		v = '0;
		sum = 0;
		flt = 1'b0;
		if (f == FUNC_PUSH) begin
			if (t != 0) begin
				times_ring[ring_wr] = t;
				ring_wr = (ring_wr + 1) % DEPTH;
				if (ring_fill < DEPTH) ring_fill++;
			end
			return v;
		end
		if (ring_fill == 0) begin
			v.good = 1'b1;
			return v;
		end
		latest = {32'd0, times_ring[(ring_wr + DEPTH - 1) % DEPTH]};
		for (int i = 1; i < ring_fill; i++) begin
			if (project_near({32'd0, times_ring[(ring_wr + DEPTH - 1 - i) % DEPTH]},
					latest, 2 * delta_q, off, flt))
				sum += off;
			else
				flt = 1'b1;
		end
		avg = sum / longint'(ring_fill);
		est = latest[31:0] + avg[31:0];
		ok = project_near({32'd0, est}, {32'd0, t}, delta_q, off, flt);
		v.good = ok && !flt;
		v.estimate_valid = 1'b1;
		v.estimate = est;
		v.fault = flt;
		return v;
	endfunction

	task automatic send_word(input logic f, input logic [31:0] t);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		sample_time <= t;
		do @(posedge clk); while (in_stall);
		verdict_q.push_back(qualify(f, t));
		n_words++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(input logic [19:0] per, input logic [19:0] dlt);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_EVENT_PERIOD;
		cfg_wdata <= per;
		@(posedge clk);
		cfg_index <= CFG_MAX_DELTA;
		cfg_wdata <= dlt;
		@(posedge clk);
		cfg_we <= 1'b0;
		period_q = 64'(per);
		delta_q = 64'(dlt);
	endtask

	// receiver with per-word stall and checking
	initial begin
		verdict_t want;
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = burst ? 0 : $urandom_range(0, 19);
			if (hold_long > 0) begin
				n = hold_long;
				hold_long = 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (verdict_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (good !== want.good) begin
					$error("good exp %0d got %0d", want.good, good);
					errors++;
				end
				if (estimate_valid !== want.estimate_valid) begin
					$error("estimate_valid exp %0d got %0d", want.estimate_valid,
						estimate_valid);
					errors++;
				end
				if (estimate !== want.estimate) begin
					$error("estimate exp %0h got %0h", want.estimate, estimate);
					errors++;
				end
				if (fault !== want.fault) begin
					$error("fault exp %0d got %0d", want.fault, fault);
					errors++;
				end
				if (want.estimate_valid) n_checks++;
				if (want.good) n_good++;
				if (want.fault) n_faults++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// daily-like run: pushes near whole periods, then checks near the next one, some at a random time
	task automatic send_sequence();
		logic [31:0] base;
		int k, jit;
		base = $urandom();
		k = $urandom_range(1, 10);
		for (int i = 0; i < k; i++) begin
			jit = int'($urandom_range(0, delta_q[19:0])) - int'(delta_q[19:0] / 2);
			send_word(FUNC_PUSH, base + i * period_q[31:0] + jit);
		end
		repeat ($urandom_range(1, 3)) begin
			jit = int'($urandom_range(0, 2 * delta_q[19:0])) - int'(delta_q[19:0]);
			if ($urandom_range(0, 5) == 0) jit = $urandom();
			send_word(FUNC_CHECK, base + k * period_q[31:0] + jit);
		end
	endtask

	task automatic send_noise();
		logic [31:0] t;
		t = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom();
		if ($urandom_range(0, 3) == 0) t = t >> $urandom_range(0, 31);
		send_word($urandom_range(0, 1) ? FUNC_PUSH : FUNC_CHECK, t);
	endtask

	task automatic test_empty_ring();
		send_word(FUNC_CHECK, 32'd1);
		send_word(FUNC_CHECK, 32'hFFFF_FFFF);
		send_word(FUNC_PUSH, 32'd0);
		send_word(FUNC_CHECK, 32'd5);
	endtask

	task automatic test_fit_and_faults();
		send_word(FUNC_PUSH, 32'd1000);
		send_word(FUNC_PUSH, 32'd1000 + 86400 + 100);
		send_word(FUNC_CHECK, 32'd1000 + 2 * 86400 - 50);
		send_word(FUNC_CHECK, 32'd1000 + 2 * 86400 + 40000);
		send_word(FUNC_CHECK, 32'd50);
		send_word(FUNC_PUSH, 32'd500000);
		send_word(FUNC_PUSH, 32'd100);
		send_word(FUNC_CHECK, 32'd86500);
		send_word(FUNC_PUSH, 32'd200000 + 86400 + 30000);
		send_word(FUNC_CHECK, 32'd200000 + 2 * 86400 + 30000);
		send_word(FUNC_PUSH, 32'hFFFF_FFFF);
		send_word(FUNC_PUSH, 32'h8000_0000);
		send_word(FUNC_CHECK, 32'hFFFF_FFFF);
		send_word(FUNC_CHECK, 32'h8000_0001);
	endtask

	task automatic test_random_mix(input int n);
		int stop;
		stop = n_words + n;
		while (n_words < stop) begin
			if ($urandom_range(0, 15) == 0) burst = !burst;
			if ($urandom_range(0, 9) < 7) send_sequence();
			else send_noise();
		end
		burst = 1'b0;
	endtask

	task automatic test_config_sweep();
		set_config(20'd1, 20'd0);
		test_random_mix(80);
		set_config(20'hFFFFF, 20'hFFFFF);
		test_random_mix(80);
		set_config(20'd0, 20'd5);
		test_random_mix(80);
		set_config(20'hFFFFF, 20'd0);
		test_random_mix(80);
		set_config(20'd1000, 20'd100);
		test_random_mix(150);
		set_config(20'd3600, 20'd600);
		test_random_mix(150);
		repeat (4) begin
			set_config(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
			test_random_mix(60);
		end
		set_config(20'(PERIOD_RESET), 20'(DELTA_RESET));
		test_random_mix(600);
	endtask

	task automatic test_output_hold();
		drain();
		hold_long = 300;
		burst = 1'b1;
		repeat (6) send_word(FUNC_PUSH, $urandom());
		send_word(FUNC_CHECK, $urandom());
		burst = 1'b0;
	endtask

	initial begin
		in_valid = 1'b0;
		func = FUNC_CHECK;
		sample_time = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_EVENT_PERIOD;
		cfg_wdata = '0;
		errors = 0;
		n_words = 0;
		n_checks = 0;
		n_good = 0;
		n_faults = 0;
		idle_cycles = 0;
		burst = 1'b0;
		hold_long = 0;
		ring_wr = 0;
		ring_fill = 0;
		period_q = 64'(PERIOD_RESET);
		delta_q = 64'(DELTA_RESET);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_ring();
		test_fit_and_faults();
		test_config_sweep();
		test_output_hold();
		drain();
		$display("sent %0d words: %0d checks, %0d good, %0d faulted", n_words,
			n_checks, n_good, n_faults);
		$display("covered period and delta extremes, empty ring, wrap and stalls");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
